/* hw/rtl/tccw_pkg.sv */
`default_nettype none
package tccw_pkg;

	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int CELL_W  = ATTR_W + CHAR_W;

	localparam int S_DATA_W = 24;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 32;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] CHR_NL        = 8'h0A;
	localparam logic [CHAR_W-1:0] CHR_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CHR_CR        = 8'h0D;
	localparam logic [CHAR_W-1:0] CHR_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] CHR_PRINT_MAX = 8'h7F;
	localparam logic [ATTR_W-1:0] ATTR_RESET    = 8'h07;
	localparam logic [COL_W:0]    TAB_STEP      = 8'd4;

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_MOVE  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_CHAR,
		CMD_TAB,
		CMD_NEWLINE,
		CMD_CR,
		CMD_MOVE,
		CMD_CLEAR,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CHAR_W-1:0] char_code;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              in_range;
	} cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/tccw_ram.sv */
`default_nettype none
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/tccw_front.sv */
`default_nettype none
module tccw_front
	import tccw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                s_tvalid,
	output      logic                s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,
	input  wire logic [S_USER_W-1:0] s_tuser,
	input  wire logic                init_busy,
	input  wire logic                q_full,
	output      logic                push,
	output      cmd_t                push_cmd
);

	logic [CHAR_W-1:0] code;
	logic [ROW_W-1:0]  trow;
	logic [COL_W-1:0]  tcol;

	assign code = s_tdata[CHAR_W-1:0];
	assign trow = s_tdata[CHAR_W +: ROW_W];
	assign tcol = s_tdata[CHAR_W+ROW_W +: COL_W];

	// hold off new beats while the screen store is swept after reset
	assign s_tready = !q_full && !init_busy;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_cmd.char_code = code;
		push_cmd.row       = trow;
		push_cmd.col       = tcol;
		push_cmd.in_range  = ({1'b0, trow} < (ROW_W+1)'(ROWS)) &&
				({1'b0, tcol} < (COL_W+1)'(COLUMNS));
		push_cmd.kind      = CMD_NOP;
		case (action_t'(s_tuser))
			ACT_PUT: begin
				case (code)
					CHR_NL:  push_cmd.kind = CMD_NEWLINE;
					CHR_TAB: push_cmd.kind = CMD_TAB;
					CHR_CR:  push_cmd.kind = CMD_CR;
					default: begin
						if (code >= CHR_SPACE && code <= CHR_PRINT_MAX) begin
							push_cmd.kind = CMD_CHAR;
						end
					end
				endcase
			end
			ACT_MOVE:  push_cmd.kind = CMD_MOVE;
			ACT_CLEAR: push_cmd.kind = CMD_CLEAR;
			ACT_READ:  push_cmd.kind = CMD_READ;
			default:   push_cmd.kind = CMD_NOP;
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/tccw_queue.sv */
`default_nettype none
module tccw_queue
	import tccw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output      logic full,
	input  wire logic pop,
	output      logic valid,
	output      cmd_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				entry_q[wr_ptr_q] <= push_cmd;
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/tccw_back.sv */
`default_nettype none
module tccw_back
	import tccw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                text_attribute_we,
	input  wire logic [ATTR_W-1:0]   text_attribute,
	input  wire logic                q_valid,
	input  wire cmd_t                q_head,
	output      logic                pop,
	output      logic                init_busy,
	output      logic                m_tvalid,
	input  wire logic                m_tready,
	output      logic [M_DATA_W-1:0] m_tdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW1   = ROW_W + 1;
	localparam int CW1   = COL_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_READ
	} state_t;

	state_t            state_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  base_q;
	logic [ATTR_W-1:0] attr_q;
	logic [AW-1:0]     sweep_addr_q;
	logic [AW-1:0]     sweep_cnt_q;
	logic [AW-1:0]     sweep_last_q;
	logic [CELL_W-1:0] sweep_data_q;
	logic              sweep_emit_q;
	logic              init_q;
	logic              m_tvalid_q;
	logic [ROW_W-1:0]  res_row_q;
	logic [COL_W-1:0]  res_col_q;
	logic [CELL_W-1:0] res_cell_q;

	logic [ROW_W-1:0]  nxt_row;
	logic [COL_W-1:0]  nxt_col;
	logic              nxt_scroll;
	logic              do_nl;
	logic [CW1-1:0]    col_inc;
	logic [CW1-1:0]    tab_col;
	logic [RW1-1:0]    row_inc;
	logic [ROW_W-1:0]  base_nxt;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// logical row r lives in physical row (r + base) mod ROWS
	function automatic logic [AW-1:0] addr_of(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c, input logic [ROW_W-1:0] b);
		logic [RW1-1:0] p;
		p = {1'b0, r} + {1'b0, b};
		if (p >= RW1'(ROWS)) begin
			p = p - RW1'(ROWS);
		end
		return AW'(AW'(p) * AW'(COLUMNS)) + AW'(c);
	endfunction

	assign pop       = (state_q == ST_IDLE) && q_valid && (!m_tvalid_q || m_tready);
	assign init_busy = init_q;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {(M_DATA_W-CELL_W-COL_W-ROW_W)'(0), res_cell_q, res_col_q, res_row_q};

	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign tab_col  = ({1'b0, col_q} + TAB_STEP) & ~CW1'(3);
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign base_nxt = (base_q == ROW_W'(ROWS-1)) ? '0 : base_q + 1'b1;

	always_comb begin
		nxt_row    = row_q;
		nxt_col    = col_q;
		nxt_scroll = 1'b0;
		do_nl      = 1'b0;
		case (q_head.kind)
			CMD_CHAR: begin
				if (col_inc >= CW1'(COLUMNS)) begin
					do_nl = 1'b1;
				end else begin
					nxt_col = col_inc[COL_W-1:0];
				end
			end
			CMD_TAB: begin
				if (tab_col >= CW1'(COLUMNS)) begin
					do_nl = 1'b1;
				end else begin
					nxt_col = tab_col[COL_W-1:0];
				end
			end
			CMD_NEWLINE: do_nl = 1'b1;
			CMD_CR:      nxt_col = '0;
			CMD_MOVE: begin
				if (q_head.in_range) begin
					nxt_row = q_head.row;
					nxt_col = q_head.col;
				end
			end
			CMD_CLEAR: begin
				nxt_row = '0;
				nxt_col = '0;
			end
			default: ;
		endcase
		if (do_nl) begin
			nxt_col = '0;
			if (row_inc >= RW1'(ROWS)) begin
				nxt_row    = ROW_W'(ROWS-1);
				nxt_scroll = 1'b1;
			end else begin
				nxt_row = row_inc[ROW_W-1:0];
			end
		end
	end

	always_comb begin
		ram_we    = (state_q == ST_SWEEP) || (pop && q_head.kind == CMD_CHAR);
		ram_waddr = (state_q == ST_SWEEP) ? sweep_addr_q : addr_of(row_q, col_q, base_q);
		ram_wdata = (state_q == ST_SWEEP) ? sweep_data_q : {attr_q, q_head.char_code};
		ram_re    = pop && q_head.kind == CMD_READ && q_head.in_range;
		ram_raddr = addr_of(q_head.row, q_head.col, base_q);
	end

	tccw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			row_q        <= '0;
			col_q        <= '0;
			base_q       <= '0;
			attr_q       <= ATTR_RESET;
			sweep_addr_q <= '0;
			sweep_cnt_q  <= '0;
			sweep_last_q <= AW'(CELLS-1);
			sweep_data_q <= {ATTR_RESET, CHR_SPACE};
			sweep_emit_q <= 1'b0;
			init_q       <= 1'b1;
			m_tvalid_q   <= 1'b0;
			res_row_q    <= '0;
			res_col_q    <= '0;
			res_cell_q   <= '0;
		end else begin
			if (text_attribute_we) begin
				attr_q <= text_attribute;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						row_q <= nxt_row;
						col_q <= nxt_col;
						if (nxt_scroll) begin
							// old top row becomes the new bottom row: blank it
							base_q       <= base_nxt;
							sweep_addr_q <= AW'(AW'(base_q) * AW'(COLUMNS));
							sweep_cnt_q  <= '0;
							sweep_last_q <= AW'(COLUMNS-1);
							sweep_data_q <= {attr_q, CHR_SPACE};
							sweep_emit_q <= 1'b1;
							state_q      <= ST_SWEEP;
						end else if (q_head.kind == CMD_CLEAR) begin
							sweep_addr_q <= '0;
							sweep_cnt_q  <= '0;
							sweep_last_q <= AW'(CELLS-1);
							sweep_data_q <= {attr_q, CHR_SPACE};
							sweep_emit_q <= 1'b1;
							state_q      <= ST_SWEEP;
						end else if (q_head.kind == CMD_READ && q_head.in_range) begin
							state_q <= ST_READ;
						end else begin
							m_tvalid_q <= 1'b1;
							res_row_q  <= nxt_row;
							res_col_q  <= nxt_col;
							res_cell_q <= '0;
						end
					end
				end
				ST_SWEEP: begin
					sweep_addr_q <= sweep_addr_q + 1'b1;
					sweep_cnt_q  <= sweep_cnt_q + 1'b1;
					if (sweep_cnt_q == sweep_last_q) begin
						state_q <= ST_IDLE;
						init_q  <= 1'b0;
						if (sweep_emit_q) begin
							m_tvalid_q <= 1'b1;
							res_row_q  <= row_q;
							res_col_q  <= col_q;
							res_cell_q <= '0;
						end
					end
				end
				ST_READ: begin
					m_tvalid_q <= 1'b1;
					res_row_q  <= row_q;
					res_col_q  <= col_q;
					res_cell_q <= ram_rdata;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/text_console_cell_writer.sv */
// Channel    Signals                                   Beat carries
// s (in)     s_tvalid s_tready s_tdata[23:0] s_tuser   one console action
// m (out)    m_tvalid m_tready m_tdata[31:0]           cursor after the action, cell read
// cfg        text_attribute_we text_attribute[7:0]     attribute for written and blank cells
//
// Moves, returns, ignored codes, and tabs, newlines and characters that do not scroll finish in
// the back end's idle state; a read also passes through ST_READ (registered memory read port).
// A scroll blanks one row through the single write port.
// A clear sweeps the whole store.
// After reset the store is swept to blanks with s_tready low.
// A two-entry queue decouples decode from execution; a stalled m side holds the queue.
`default_nettype none
module text_console_cell_writer
	import tccw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output      logic                s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // char_code[7:0], target_row[12:8], target_col[19:13]
	input  wire logic [S_USER_W-1:0] s_tuser,  // action[1:0]
	output      logic                m_tvalid,
	input  wire logic                m_tready,
	output      logic [M_DATA_W-1:0] m_tdata,  // cursor_row[4:0], cursor_col[11:5], cell_value[27:12]
	input  wire logic                text_attribute_we,
	input  wire logic [ATTR_W-1:0]   text_attribute
);

	logic init_busy;
	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic q_valid;
	logic pop;
	cmd_t q_head;

	tccw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.init_busy (init_busy),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	tccw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	tccw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.text_attribute_we (text_attribute_we),
		.text_attribute    (text_attribute),
		.q_valid           (q_valid),
		.q_head            (q_head),
		.pop               (pop),
		.init_busy         (init_busy),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata)
	);

endmodule
`default_nettype wire

/* hw/rtl/tccw_checker.sv */
`default_nettype none
module tccw_checker
	import tccw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata
);

	logic [ROW_W-1:0]  out_row;
	logic [COL_W-1:0]  out_col;
	logic [CHAR_W-1:0] out_char;
	logic [CELL_W-1:0] out_cell;
	logic              seen_in_q;

	assign out_row  = m_tdata[ROW_W-1:0];
	assign out_col  = m_tdata[ROW_W +: COL_W];
	assign out_cell = m_tdata[ROW_W+COL_W +: CELL_W];
	assign out_char = out_cell[CHAR_W-1:0];

	// note the first input beat after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			seen_in_q <= 1'b1;
		end
	end

	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_m_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("stalled result beat changed");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, out_row} < (ROW_W+1)'(ROWS)) &&
			({1'b0, out_col} < (COL_W+1)'(COLUMNS)))
		else $error("cursor outside the screen");

	a_cell_printable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_cell == '0) ||
			(out_char >= CHR_SPACE && out_char <= CHR_PRINT_MAX))
		else $error("cell holds a non-printable code");

	a_no_result_before_input: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_in_q |-> !m_tvalid)
		else $error("result appeared with no beat taken");

endmodule

bind text_console_cell_writer tccw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tccw_checker (.*);
`default_nettype wire
